>>> hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    // Number of cells in the chain, and the width of the occupancy counter.
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 5;
    localparam int PRI_W    = 16;
    localparam int TAG_W    = 24;

    typedef enum logic {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_kind                    kind;
        logic signed [PRI_W-1:0]  new_priority;
        logic [TAG_W-1:0]         new_tag;
    } t_in;

    typedef struct packed {
        t_status                  status;
        logic signed [PRI_W-1:0]  removed_priority;
        logic [TAG_W-1:0]         removed_tag;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
        logic [TAG_W-1:0]         head_tag;
        logic [TAG_W-1:0]         tail_tag;
    } t_out;

    // One stored entry of the queue.
    typedef struct packed {
        logic signed [PRI_W-1:0]  priority_val;
        logic [TAG_W-1:0]         tag;
    } t_entry;

    // Operation broadcast to every cell in the chain.
    typedef struct packed {
        logic                     enq;
        logic                     deq;
        t_entry                   item;
    } t_ctl;

endpackage

>>> hw/rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: the cell chain, occupancy and result register.
//
//  Channel  Direction  Signals                              Carries
//  in       in         i_in_valid, o_in_stall, i_in_data    enqueue or dequeue request
//  out      out        o_out_valid, i_out_stall, o_out_data one result per request
//
// For every accepted request all cells compare against the new priority and shift
// in parallel, and the result is registered at the same edge.
// A new request is taken each cycle while the result register is free or being emptied.
// Reset clears the occupancy count and the result valid; cell contents are left as they are.
// A stalled output holds its result and stalls the input until it is taken.
module sorted_priority_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  spq_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output spq_pkg::t_out o_out_data
);
    import spq_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [TAG_W-1:0] r_tail;
    logic [TAG_W-1:0] n_tail;
    logic             r_out_valid;
    t_out             r_out;
    t_out             n_out;

    t_entry           cell_q  [CAPACITY];
    t_entry           left_in [CAPACITY];
    t_entry           right_in[CAPACITY];
    logic [CAPACITY-1:0] occ;
    logic [CAPACITY-1:0] sh;
    logic [CAPACITY-1:0] left_sh;

    logic  fire;
    logic  full;
    logic  empty;
    logic  enq_ok;
    logic  deq_ok;
    logic  append;
    t_ctl  ctl;

    // Handshake: the result register parts the two sides.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign fire       = i_in_valid && !o_in_stall;

    assign full   = (r_count == CNT_W'(CAPACITY));
    assign empty  = (r_count == '0);
    assign enq_ok = fire && (i_in_data.kind == KIND_ENQ) && !full;
    assign deq_ok = fire && (i_in_data.kind == KIND_DEQ) && !empty;

    assign ctl.enq                = enq_ok;
    assign ctl.deq                = deq_ok;
    assign ctl.item.priority_val  = i_in_data.new_priority;
    assign ctl.item.tag           = i_in_data.new_tag;

    // The chain of cells, each wired to its neighbours.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign occ[g] = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_first
            assign left_sh[g] = 1'b0;
            assign left_in[g] = '0;
        end else begin : g_mid
            assign left_sh[g] = sh[g-1];
            assign left_in[g] = cell_q[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_in[g] = '0;
        end else begin : g_inner
            assign right_in[g] = cell_q[g+1];
        end

        spq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_occ     (occ[g]),
            .i_left_sh (left_sh[g]),
            .i_left    (left_in[g]),
            .i_right   (right_in[g]),
            .o_entry   (cell_q[g]),
            .o_sh      (sh[g])
        );
    end

    // The new entry lands at the tail when no stored priority exceeds it.
    assign append = ~|(sh & occ);

    // Next occupancy and tail tag.
    always_comb begin
        n_count = r_count;
        n_tail  = r_tail;
        if (enq_ok) begin
            n_count = r_count + 1'b1;
            if (append) begin
                n_tail = i_in_data.new_tag;
            end
        end else if (deq_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    // Result describing the queue after the request.
    always_comb begin
        n_out                  = '0;
        n_out.status           = ST_OK;
        n_out.count            = COUNT_W'(n_count);
        n_out.is_empty         = (n_count == '0);
        n_out.head_tag         = cell_q[0].tag;
        if (i_in_data.kind == KIND_ENQ) begin
            if (full) begin
                n_out.status = ST_FULL;
            end else if (sh[0]) begin
                n_out.head_tag = i_in_data.new_tag;
            end
        end else begin
            if (empty) begin
                n_out.status = ST_UNDER;
            end else begin
                n_out.removed_priority = cell_q[0].priority_val;
                n_out.removed_tag      = cell_q[0].tag;
                n_out.head_tag         = cell_q[1].tag;
            end
        end
        n_out.tail_tag = n_tail;
        if (n_count == '0) begin
            n_out.head_tag = '0;
            n_out.tail_tag = '0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_tail <= n_tail;
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> hw/rtl/spq_cell.sv
// One cell of the sorted chain: holds a single entry and shifts with its neighbours.
module spq_cell (
    input  logic           i_clk,
    input  spq_pkg::t_ctl   i_ctl,
    input  logic           i_occ,
    input  logic           i_left_sh,
    input  spq_pkg::t_entry i_left,
    input  spq_pkg::t_entry i_right,
    output spq_pkg::t_entry o_entry,
    output logic           o_sh
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // An empty cell, or one whose priority is strictly greater, gives way.
    assign o_sh    = !i_occ || (r_entry.priority_val > i_ctl.item.priority_val);
    assign o_entry = r_entry;

    // First cell giving way takes the item, later ones the left; dequeue: the right.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.enq && o_sh) begin
            n_entry = i_left_sh ? i_left : i_ctl.item;
        end else if (i_ctl.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

>>> hw/rtl/spq_checker.sv
// Port-level assertions for the sorted priority queue, bound to the top level.
module spq_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input spq_pkg::t_out o_out_data
);
    import spq_pkg::*;

    // The empty flag of a valid result always agrees with the count.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.is_empty == (o_out_data.count == '0)))
        else $error("is_empty disagrees with count");

    // An empty queue reports no head or tail.
    a_empty_tags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.is_empty) |->
            (o_out_data.head_tag == '0 && o_out_data.tail_tag == '0))
        else $error("empty queue shows a head or tail tag");

    // Underflow leaves the queue empty and removes nothing.
    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_UNDER) |->
            (o_out_data.count == '0 && o_out_data.removed_tag == '0 &&
             o_out_data.removed_priority == '0))
        else $error("underflow result is inconsistent");

    // A refused enqueue only happens on a full queue.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_FULL) |->
            (o_out_data.count == COUNT_W'(CAPACITY) && o_out_data.removed_tag == '0))
        else $error("full status on a queue that is not full");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

>>> bench/sorted_priority_queue_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sorted priority queue: shadow queue, result checker and flow-control phases.
module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int MAX_REPORTS = 10;
    localparam int PHASE_ITEMS = 457;

    // Clock, reset and the two channels.
    logic  i_clk      = 1'b0;
    logic  i_rst_n    = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_stall;
    t_in   i_in_data  = '0;
    logic  o_out_valid;
    logic  i_out_stall = 1'b0;
    t_out  o_out_data;

    // Shadow copy of the queue contents, sorted ascending with slot 0 at the head.
    logic signed [PRI_W-1:0] held_pri [CAPACITY];
    logic [TAG_W-1:0]        held_tag [CAPACITY];
    int                      held_count = 0;

    // Results predicted for accepted requests, oldest first.
    t_out pending_results [$];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    bit draining           = 1'b0;

    int mismatches      = 0;
    int results_checked = 0;
    int enq_requests    = 0;
    int deq_requests    = 0;
    int full_refusals   = 0;
    int underflows      = 0;

    sorted_priority_queue DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // A 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Applies one request to the shadow queue and returns the result it should give.
    function automatic t_out apply_request(input t_in req);
        t_out res;
        int   pos;
        res        = '0;
        res.status = ST_OK;
        if (req.kind == KIND_ENQ) begin
            enq_requests++;
            if (held_count >= CAPACITY) begin
                res.status = ST_FULL;
                full_refusals++;
            end else begin
                // The new entry goes ahead of the first one with a strictly greater priority.
                pos = held_count;
                for (int i = held_count - 1; i >= 0; i--) begin
                    if ($signed(held_pri[i]) > $signed(req.new_priority)) pos = i;
                end
                for (int i = held_count; i > pos; i--) begin
                    held_pri[i] = held_pri[i-1];
                    held_tag[i] = held_tag[i-1];
                end
                held_pri[pos] = req.new_priority;
                held_tag[pos] = req.new_tag;
                held_count++;
            end
        end else begin
            deq_requests++;
            if (held_count == 0) begin
                res.status = ST_UNDER;
                underflows++;
            end else begin
                res.removed_priority = held_pri[0];
                res.removed_tag      = held_tag[0];
                for (int i = 1; i < held_count; i++) begin
                    held_pri[i-1] = held_pri[i];
                    held_tag[i-1] = held_tag[i];
                end
                held_count--;
            end
        end
        // The result describes the queue after the operation.
        res.count    = COUNT_W'(held_count);
        res.is_empty = (held_count == 0);
        if (held_count != 0) begin
            res.head_tag = held_tag[0];
            res.tail_tag = held_tag[held_count-1];
        end
        return res;
    endfunction

    function automatic t_in make_req(input t_kind k, input logic signed [PRI_W-1:0] p,
                                     input logic [TAG_W-1:0] t);
        t_in req;
        req.kind         = k;
        req.new_priority = p;
        req.new_tag      = t;
        return req;
    endfunction

    // Random request that sweeps the queue between empty and full, with a quarter of the
    // requests going against the sweep so that full and empty are overrun now and then.
    function automatic t_in random_request();
        t_in req;
        bit  go_deq;
        if (held_count >= CAPACITY) draining = 1'b1;
        else if (held_count == 0) draining = 1'b0;
        else if ($urandom_range(99) < 3) draining = !draining;
        go_deq = draining;
        if ($urandom_range(99) < 25) go_deq = !go_deq;
        req.kind = go_deq ? KIND_DEQ : KIND_ENQ;
        // Narrow priorities give many ties; the extremes and the full range follow.
        case ($urandom_range(9))
            0, 1, 2, 3: req.new_priority = PRI_W'(int'($urandom_range(6)) - 3);
            4:          req.new_priority = $urandom_range(1) ? 16'sh8000 : 16'sh7FFF;
            default:    req.new_priority = PRI_W'($urandom);
        endcase
        if ($urandom_range(1))
            req.new_tag = {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
                           8'($urandom_range(48, 57))};
        else
            req.new_tag = TAG_W'($urandom);
        return req;
    endfunction

    function automatic string describe(input t_out r);
        return $sformatf("status=%s removed=%0d/%06h count=%0d empty=%0b head=%06h tail=%06h",
                         r.status.name(), $signed(r.removed_priority), r.removed_tag, r.count,
                         r.is_empty, r.head_tag, r.tail_tag);
    endfunction

    // Sends one request after a random idle gap and records its expected result on acceptance.
    task automatic send_request(input t_in req);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(apply_request(req));
    endtask

    // Random back-pressure on the result channel.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Compares every accepted result with the oldest prediction, field by field.
    always @(posedge i_clk) begin
        t_out exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result %s", $time, describe(o_out_data));
            end else begin
                exp_res = pending_results.pop_front();
                if (o_out_data.status !== exp_res.status ||
                    o_out_data.removed_priority !== exp_res.removed_priority ||
                    o_out_data.removed_tag !== exp_res.removed_tag ||
                    o_out_data.count !== exp_res.count ||
                    o_out_data.is_empty !== exp_res.is_empty ||
                    o_out_data.head_tag !== exp_res.head_tag ||
                    o_out_data.tail_tag !== exp_res.tail_tag) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: result differs", $time);
                        $display("  expected %s", describe(exp_res));
                        $display("  actual   %s", describe(o_out_data));
                    end
                end
            end
        end
    end

    // Corner cases: underflow, extreme priorities and tags, ties, a full queue and a refusal.
    task automatic test_directed_corners();
        send_request(make_req(KIND_DEQ, 16'sd0, '0));
        send_request(make_req(KIND_ENQ, 16'sh7FFF, 24'hFFFFFF));
        send_request(make_req(KIND_ENQ, 16'sh8000, 24'h000000));
        send_request(make_req(KIND_ENQ, 16'sd0, "EQa"));
        send_request(make_req(KIND_ENQ, 16'sd0, "EQb"));
        send_request(make_req(KIND_ENQ, -16'sd1, "NEG"));
        send_request(make_req(KIND_ENQ, 16'sd1, "POS"));
        send_request(make_req(KIND_DEQ, 16'sd0, '0));
        send_request(make_req(KIND_ENQ, 16'sh8000, "MIN"));
        send_request(make_req(KIND_ENQ, 16'sh7FFF, "TOP"));
        // Fill the rest of the queue, then push once more against a full queue.
        while (held_count < CAPACITY)
            send_request(make_req(KIND_ENQ, PRI_W'(held_count * 7 - 50), {"F", 16'(held_count)}));
        send_request(make_req(KIND_ENQ, 16'sd5, "OVR"));
        send_request(make_req(KIND_DEQ, 16'sd0, '0));
        send_request(make_req(KIND_DEQ, 16'sd0, '0));
    endtask

    task automatic run_random_requests(input int n);
        repeat (n) send_request(random_request());
    endtask

    task automatic test_streaming();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        run_random_requests(PHASE_ITEMS);
    endtask

    task automatic test_sender_gaps();
        sender_idle_pct    = 58;
        receiver_stall_pct = 0;
        run_random_requests(PHASE_ITEMS);
    endtask

    task automatic test_receiver_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 58;
        run_random_requests(PHASE_ITEMS);
    endtask

    task automatic test_both_sides_idle();
        sender_idle_pct    = 28;
        receiver_stall_pct = 28;
        run_random_requests(PHASE_ITEMS);
    endtask

    // Reset, the tests in turn, then drain and report.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_corners();
        test_streaming();
        test_sender_gaps();
        test_receiver_backpressure();
        test_both_sides_idle();
        i_in_valid         <= 1'b0;
        receiver_stall_pct = 0;
        wait (pending_results.size() == 0);
        repeat (4) @(posedge i_clk);
        $display("Checked %0d results: %0d enqueues (%0d refused as full), %0d dequeues (%0d underflows).",
                 results_checked, enq_requests, full_refusals, deq_requests, underflows);
        $display("Flow control covered streaming, sender gaps, receiver back-pressure and both together.");
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2_000_000;
        $display("Timed out with %0d results outstanding.", pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
